[rtl/assert_macros.svh]
// Assertion macros used by the RTL back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/twcc_pkg.sv]
// Shared types, codes and constants of the text window cursor control block.
`timescale 1ns / 1ps

package twcc_pkg;

    localparam int COORD_BITS  = 8;
    localparam int CFG_BITS    = 8;
    localparam int TAB_BITS    = 4;
    localparam int CMP_W       = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result action codes.
    localparam logic [1:0] ACT_GLYPH  = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_BEEP   = 2'd2;
    localparam logic [1:0] ACT_MOVE   = 2'd3;

    // Operation kinds passed from the front to the back.
    localparam logic [2:0] OP_GLYPH = 3'd0;
    localparam logic [2:0] OP_BEEP  = 3'd1;
    localparam logic [2:0] OP_BS    = 3'd2;
    localparam logic [2:0] OP_CR    = 3'd3;
    localparam logic [2:0] OP_LF    = 3'd4;
    localparam logic [2:0] OP_LOAD  = 3'd5;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [2:0] REG_WIN_TOP    = 3'd1;
    localparam logic [2:0] REG_WIN_WIDTH  = 3'd2;
    localparam logic [2:0] REG_WIN_HEIGHT = 3'd3;
    localparam logic [2:0] REG_TAB_WIDTH  = 3'd4;

    typedef struct packed {
        logic [CFG_BITS-1:0] win_left;
        logic [CFG_BITS-1:0] win_top;
        logic [CFG_BITS-1:0] win_width;
        logic [CFG_BITS-1:0] win_height;
        logic [TAB_BITS-1:0] tab_width;
    } cfg_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          glyph;
        logic [TAB_BITS-1:0] count;
        logic [7:0]          load_col;
        logic [7:0]          load_row;
    } op_t;

endpackage

[rtl/twcc_front.sv]
// Front end: accepts characters and load commands and classifies them into operations.
`timescale 1ns / 1ps

module twcc_front
    import twcc_pkg::*;
(
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // ch [7:0], load_col [15:8], load_row [23:16]
    input  logic        s_tuser,    // cmd
    input  cfg_t        cfg,
    input  logic        q_full,
    output logic        q_push,
    output op_t         q_op
);

    logic [7:0] ch;
    logic       drop;

    assign ch       = s_tdata[7:0];
    assign s_tready = !q_full;

    always_comb begin
        q_op          = '0;
        q_op.glyph    = ch;
        q_op.count    = TAB_BITS'(1);
        q_op.load_col = s_tdata[15:8];
        q_op.load_row = s_tdata[23:16];
        q_op.kind     = OP_GLYPH;
        drop          = 1'b0;
        if (s_tuser) begin
            q_op.kind = OP_LOAD;
        end else begin
            unique case (ch)
                CH_BEL: q_op.kind = OP_BEEP;
                CH_BS:  q_op.kind = OP_BS;
                CH_CR:  q_op.kind = OP_CR;
                CH_LF:  q_op.kind = OP_LF;
                CH_HT: begin
                    // A tab becomes a run of spaces under the printable rule.
                    q_op.glyph = CH_SPACE;
                    q_op.count = cfg.tab_width;
                    drop       = (cfg.tab_width == '0);
                end
                CH_FF, CH_VT, CH_NUL: drop = 1'b1;
                default: q_op.kind = OP_GLYPH;
            endcase
        end
    end

    assign q_push = s_tvalid && s_tready && !drop && aresetn;

endmodule

[rtl/twcc_fifo.sv]
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps

module twcc_fifo
    import twcc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head_op
);

    op_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[rtl/twcc_back.sv]
// Back end: holds the cursor, carries out queued operations and registers each result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module twcc_back
    import twcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        head_valid,
    input  op_t         head_op,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // glyph [7:0], at_col [15:8], at_row [23:16]
    output logic [1:0]  m_tuser,    // action
    output logic        m_tlast
);

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  scroll_pend_reg, scroll_pend_next;
    logic [TAB_BITS-1:0]   done_reg, done_next;

    logic                  out_valid_reg;
    logic [1:0]            out_action_reg;
    logic [7:0]            out_glyph_reg, out_col_reg, out_row_reg;
    logic                  out_last_reg;

    logic                  slot_free, emit;
    logic [1:0]            res_action;
    logic [7:0]            res_glyph, res_col, res_row;
    logic                  res_last;

    logic [CMP_W-1:0]      col_w, row_w, left_w, top_w, eff_w, eff_h;
    logic [CMP_W-1:0]      right_excl, bottom_excl, col_inc, g_col, g_row;
    logic                  g_wrap, g_scroll;
    logic [TAB_BITS-1:0]   done_inc;

    assign col_w       = CMP_W'(col_reg);
    assign row_w       = CMP_W'(row_reg);
    assign left_w      = CMP_W'(cfg.win_left);
    assign top_w       = CMP_W'(cfg.win_top);
    assign eff_w       = (cfg.win_width == '0) ? CMP_W'(1) : CMP_W'(cfg.win_width);
    assign eff_h       = (cfg.win_height == '0) ? CMP_W'(1) : CMP_W'(cfg.win_height);
    assign right_excl  = left_w + eff_w;
    assign bottom_excl = top_w + eff_h;

    // Printable step: advance, wrap at the right edge, clamp to the bottom row on scroll.
    assign col_inc  = col_w + 1'b1;
    assign g_wrap   = (col_inc >= right_excl);
    assign g_col    = g_wrap ? left_w : col_inc;
    assign g_row    = g_wrap ? row_w + 1'b1 : row_w;
    assign g_scroll = (g_row >= bottom_excl);
    assign done_inc = done_reg + 1'b1;

    assign slot_free = !out_valid_reg || m_tready;

    always_comb begin
        emit             = 1'b0;
        pop              = 1'b0;
        res_action       = ACT_MOVE;
        res_glyph        = '0;
        res_col          = 8'(col_reg);
        res_row          = 8'(row_reg);
        res_last         = 1'b1;
        col_next         = col_reg;
        row_next         = row_reg;
        scroll_pend_next = scroll_pend_reg;
        done_next        = done_reg;
        if (head_valid && slot_free) begin
            if (scroll_pend_reg) begin
                // Second result of a glyph that pushed the cursor past the bottom row.
                emit             = 1'b1;
                res_action       = ACT_SCROLL;
                res_last         = (done_reg == head_op.count);
                scroll_pend_next = 1'b0;
                if (res_last) begin
                    pop       = 1'b1;
                    done_next = '0;
                end
            end else begin
                unique case (head_op.kind)
                    OP_GLYPH: begin
                        emit       = 1'b1;
                        res_action = ACT_GLYPH;
                        res_glyph  = head_op.glyph;
                        col_next   = COORD_BITS'(g_col);
                        if (g_scroll) begin
                            row_next         = COORD_BITS'(bottom_excl - 1'b1);
                            scroll_pend_next = 1'b1;
                            done_next        = done_inc;
                            res_last         = 1'b0;
                        end else begin
                            row_next = COORD_BITS'(g_row);
                            res_last = (done_inc == head_op.count);
                            if (res_last) begin
                                pop       = 1'b1;
                                done_next = '0;
                            end else begin
                                done_next = done_inc;
                            end
                        end
                    end
                    OP_BEEP: begin
                        emit       = 1'b1;
                        pop        = 1'b1;
                        res_action = ACT_BEEP;
                    end
                    OP_BS: begin
                        pop = 1'b1;
                        if (col_w > left_w) begin
                            emit     = 1'b1;
                            col_next = col_reg - 1'b1;
                            res_col  = 8'(col_next);
                        end
                    end
                    OP_CR: begin
                        emit     = 1'b1;
                        pop      = 1'b1;
                        col_next = COORD_BITS'(cfg.win_left);
                        res_col  = 8'(col_next);
                    end
                    OP_LF: begin
                        emit     = 1'b1;
                        pop      = 1'b1;
                        col_next = COORD_BITS'(cfg.win_left);
                        res_col  = 8'(col_next);
                        if (row_w >= bottom_excl - 1'b1) begin
                            res_action = ACT_SCROLL;
                            row_next   = COORD_BITS'(bottom_excl - 1'b1);
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                        res_row = 8'(row_next);
                    end
                    OP_LOAD: begin
                        emit     = 1'b1;
                        pop      = 1'b1;
                        col_next = COORD_BITS'(head_op.load_col);
                        row_next = COORD_BITS'(head_op.load_row);
                        res_col  = 8'(col_next);
                        res_row  = 8'(row_next);
                    end
                    default: pop = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            scroll_pend_reg <= 1'b0;
            done_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            scroll_pend_reg <= scroll_pend_next;
            done_reg        <= done_next;
            if (slot_free) begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && emit) begin
            out_action_reg <= res_action;
            out_glyph_reg  <= res_glyph;
            out_col_reg    <= res_col;
            out_row_reg    <= res_row;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_glyph_reg};
    assign m_tlast  = out_last_reg;

    `TWCC_ASSERT_IMP(a_scroll_has_op, aclk, aresetn, scroll_pend_reg, head_valid, "pending scroll without an operation")
    `TWCC_ASSERT_IMP(a_run_in_range, aclk, aresetn, head_valid && !scroll_pend_reg, done_reg < head_op.count || head_op.kind != OP_GLYPH, "glyph run counter past its end")
    `TWCC_ASSERT_NEXT(a_pop_clears_run, aclk, aresetn, pop, done_reg == '0 && !scroll_pend_reg, "run state left over after an operation completed")

endmodule

[rtl/text_window_cursor_control.sv]
// An input transfer is queued, and its result is registered when the output is free.
// Throughput: one transfer per cycle unless the queue is full; a tab gives one space a cycle
// and a glyph that scrolls a glyph then a scroll result while the single result register of
// the back end is free. The four-entry queue lets input transfers go on while results stall.
// Reset (aresetn low, synchronous) clears the cursor, the queue and the output stage
// and sets the window registers to 0, 0, 80, 25 and the tab width to 4.
`timescale 1ns / 1ps

module text_window_cursor_control
    import twcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // ch [7:0], load_col [15:8], load_row [23:16]
    input  logic        s_tuser,    // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // glyph [7:0], at_col [15:8], at_row [23:16]
    output logic [1:0]  m_tuser,    // action
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       q_full, q_push, q_pop, head_valid;
    op_t        q_op, head_op;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_WIN_LEFT:   cfg_next.win_left   = pwdata[CFG_BITS-1:0];
                REG_WIN_TOP:    cfg_next.win_top    = pwdata[CFG_BITS-1:0];
                REG_WIN_WIDTH:  cfg_next.win_width  = pwdata[CFG_BITS-1:0];
                REG_WIN_HEIGHT: cfg_next.win_height = pwdata[CFG_BITS-1:0];
                REG_TAB_WIDTH:  cfg_next.tab_width  = pwdata[TAB_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIN_LEFT:   prdata = 32'(cfg_reg.win_left);
            REG_WIN_TOP:    prdata = 32'(cfg_reg.win_top);
            REG_WIN_WIDTH:  prdata = 32'(cfg_reg.win_width);
            REG_WIN_HEIGHT: prdata = 32'(cfg_reg.win_height);
            REG_TAB_WIDTH:  prdata = 32'(cfg_reg.tab_width);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_left   <= '0;
            cfg_reg.win_top    <= '0;
            cfg_reg.win_width  <= CFG_BITS'(80);
            cfg_reg.win_height <= CFG_BITS'(25);
            cfg_reg.tab_width  <= TAB_BITS'(4);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    twcc_front u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_op)
    );

    twcc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    twcc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
